### design/drc_pkg.sv
// Shared types, constants and table-building functions for the range compressor.
package drc_pkg;

	localparam int LogTableBitsDef = 8;
	localparam int MaxChannels     = 2;
	localparam int EnvW            = 25;
	localparam int NormSteps       = 5;
	localparam int MulW            = 26;
	localparam int CfgIndexW       = 3;
	localparam int CfgDataW        = 24;

	typedef enum logic [CfgIndexW-1:0] {
		REG_CHANNEL_COUNT = 3'd0,
		REG_THRESHOLD     = 3'd1,
		REG_SLOPE         = 3'd2,
		REG_ATTACK        = 3'd3,
		REG_RELEASE       = 3'd4,
		REG_MAKEUP        = 3'd5
	} drc_reg_t;

	typedef struct packed {
		logic [1:0]  channel_count;
		logic [15:0] threshold_log2;
		logic [15:0] slope;
		logic [23:0] attack_coeff;
		logic [23:0] release_coeff;
		logic [15:0] makeup_gain;
	} drc_cfg_t;

	typedef struct packed {
		logic            last;
		logic [4:0]      shamt;
		logic [EnvW-1:0] value;
	} drc_norm_t;

	localparam logic [1:0]  RstChannelCount = 2'd2;
	localparam logic [15:0] RstThreshold    = 16'hF800;
	localparam logic [15:0] RstSlope        = 16'd49152;
	localparam logic [23:0] RstAttack       = 24'd16742300;
	localparam logic [23:0] RstRelease      = 24'd16773721;
	localparam logic [15:0] RstMakeup       = 16'd4096;

	// Bitwise integer square root, elaboration use only.
	function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
		logic [63:0] v;
		logic [63:0] res;
		logic [63:0] bval;
		int k;
		v = v_in;
		res = '0;
		bval = 64'd1 << 62;
		for (k = 0; k < 32; k++) begin
			if (bval > v) bval = bval >> 2;
		end
		for (k = 0; k < 32; k++) begin
			if (bval != 0) begin
				if (v >= res + bval) begin
					v = v - (res + bval);
					res = (res >> 1) + bval;
				end else begin
					res = res >> 1;
				end
				bval = bval >> 2;
			end
		end
		return res;
	endfunction

	// 16-bit fraction of log2(1 + idx/2^bits) by repeated squaring.
	function automatic logic [15:0] log_entry(input logic [63:0] idx, input int bits);
		logic [63:0] x;
		logic [63:0] frac;
		int k;
		x = ((64'd1 << bits) + idx) << (30 - bits);
		frac = '0;
		for (k = 0; k < 16; k++) begin
			x = (x * x) >> 30;
			frac = frac << 1;
			if (x >= (64'd1 << 31)) begin
				frac = frac | 64'd1;
				x = x >> 1;
			end
		end
		return frac[15:0];
	endfunction

	// 2^(idx/2^bits) in Q1.30 from a chain of square roots of two.
	function automatic logic [63:0] exp_entry(input logic [63:0] idx, input int bits);
		logic [63:0] p;
		logic [63:0] rt;
		int k;
		p = 64'd1 << 30;
		rt = 64'd2 << 30;
		for (k = 1; k <= 12; k++) begin
			if (k <= bits) begin
				rt = isqrt64(rt << 30);
				if (((idx >> (bits - k)) & 64'd1) != 0) p = (p * rt) >> 30;
			end
		end
		return p;
	endfunction

	// Rounded 2^46 / p by long division, giving the Q.16 gain for a fraction index.
	function automatic logic [16:0] recip_entry(input logic [63:0] idx, input int bits);
		logic [63:0] p;
		logic [63:0] num;
		logic [63:0] rem;
		logic [63:0] quo;
		int k;
		p = exp_entry(idx, bits);
		num = (64'd1 << 46) + (p >> 1);
		rem = '0;
		quo = '0;
		for (k = 47; k >= 0; k--) begin
			rem = (rem << 1) | {63'd0, num[k]};
			if (rem >= p) begin
				rem = rem - p;
				quo[k] = 1'b1;
			end
		end
		return quo[16:0];
	endfunction

endpackage

### design/dynamic_range_compressor.sv
// Compressor top level: sequencer and envelope / gain datapath around one multiplier.
//
//   channel   handshake               payload
//   -------   ---------------------   ------------------------------------------
//   frame     frame_valid/stall       sample_ch0, sample_ch1, block_start
//   result    result_valid/stall      out_ch0, out_ch1, applied_gain, clipped
//   config    cfg_valid/ready         cfg_index, cfg_data
//
// Frames are taken only in idle, one at a time, through the single shared multiplier
// (up to five products in turn) and the five-step leading-one search; a zero envelope
// skips normalizing, log and reduction; one at or below threshold skips reduction.
// Reset puts the sequencer in idle, clears the envelope and loads register defaults.
// A stalled result holds in the output register; the next frame is accepted meanwhile
// and waits in its last step only if the output register is still full.
module dynamic_range_compressor #(
	parameter int LOG_TABLE_BITS = drc_pkg::LogTableBitsDef
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          frame_valid,
	output logic                          frame_stall,
	input  logic signed [15:0]            sample_ch0,
	input  logic signed [15:0]            sample_ch1,
	input  logic                          block_start,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic signed [15:0]            out_ch0,
	output logic signed [15:0]            out_ch1,
	output logic [15:0]                   applied_gain,
	output logic                          clipped,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [drc_pkg::CfgIndexW-1:0] cfg_index,
	input  logic [drc_pkg::CfgDataW-1:0]  cfg_data
);
	import drc_pkg::*;

	localparam logic [16:0]     UnityGain = 17'h10000;
	localparam logic [EnvW-1:0] EnvMax    = 25'h800000;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PEAK,
		ST_ENV_MUL,
		ST_ENV_UPD,
		ST_NORM,
		ST_LOG,
		ST_RED_MUL,
		ST_RED,
		ST_MK_MUL,
		ST_GAIN,
		ST_CH0_MUL,
		ST_CH1_MUL,
		ST_CH1_SAT
	} state_t;

	function automatic logic [16:0] mag17(input logic [15:0] s);
		logic [16:0] res;
		res = s[15] ? 17'(17'd0 - {1'b1, s}) : {1'b0, s};
		return res;
	endfunction

	// round half up of p / 4096, saturated; returns {clip, value}
	function automatic logic [16:0] sat_q12(input logic signed [32:0] p);
		logic signed [32:0] sum;
		logic signed [20:0] q;
		logic [16:0]        res;
		sum = p + 33'sd2048;
		q = $signed(sum[32:12]);
		if (q > 21'sd32767) res = {1'b1, 16'h7FFF};
		else if (q < -21'sd32768) res = {1'b1, 16'h8000};
		else res = {1'b0, q[15:0]};
		return res;
	endfunction

	drc_cfg_t  cfg;
	drc_norm_t norm;
	state_t    state_q;

	logic signed [15:0] s0_q, s1_q;
	logic               start_q, two_ch_q, rising_q;
	logic [EnvW-1:0]    env_q, peak_q, diff_q;
	logic [21:0]        excess_q;
	logic [16:0]        comp_q;
	logic [15:0]        g_q;
	logic signed [15:0] o0_q;
	logic               clip0_q;
	logic               res_valid_q;
	logic signed [15:0] out_ch0_q, out_ch1_q;
	logic [15:0]        gain_q;
	logic               clip_q;

	logic signed [MulW-1:0]   mul_a, mul_b;
	logic signed [2*MulW-1:0] prod_q;

	logic                      two_ch_c;
	logic [16:0]               mag0, mag1;
	logic [EnvW-1:0]           peak_c, base_c, diff_c;
	logic                      rising_c;
	logic [48:0]               env_rnd;
	logic [EnvW-1:0]           env_step, env_new;
	logic [LOG_TABLE_BITS-1:0] log_idx, exp_idx;
	logic [15:0]               log_frac;
	logic [16:0]               recip;
	logic [7:0]                exp_hi;
	logic [23:0]               lg;
	logic [21:0]               thr64;
	logic [25:0]               excess_c;
	logic                      excess_pos;
	logic [37:0]               rsum;
	logic [21:0]               r;
	logic [16:0]               comp_c;
	logic [32:0]               gsum;
	logic [15:0]               g_c;
	logic [16:0]               sat_c;
	logic                      out_free;
	logic                      res_load;

	drc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	drc_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	drc_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (state_q == ST_ENV_UPD),
		.value  (env_new),
		.status (norm)
	);

	drc_tables #(
		.LOG_TABLE_BITS (LOG_TABLE_BITS)
	) u_tables (
		.log_idx  (log_idx),
		.exp_idx  (exp_idx),
		.log_frac (log_frac),
		.recip    (recip)
	);

	assign cfg_ready   = 1'b1;
	assign frame_stall = (state_q != ST_IDLE);
	assign two_ch_c    = (cfg.channel_count >= 2'd2) && (MaxChannels > 1);

	// peak and envelope distance
	assign mag0     = mag17(s0_q);
	assign mag1     = mag17(s1_q);
	assign peak_c   = {(two_ch_q && (mag1 > mag0)) ? mag1 : mag0, 8'd0};
	assign base_c   = start_q ? '0 : env_q;
	assign rising_c = (peak_c > base_c);
	assign diff_c   = rising_c ? (peak_c - base_c) : (base_c - peak_c);

	assign env_rnd  = prod_q[48:0] + 49'd8388608;
	assign env_step = env_rnd[48:24];
	assign env_new  = rising_q ? (peak_q - env_step) : (peak_q + env_step);

	// log2 of the normalized envelope minus the threshold, both in Q.16
	assign log_idx    = norm.value[EnvW-2 -: LOG_TABLE_BITS];
	assign exp_hi     = 8'd1 - {3'd0, norm.shamt};
	assign lg         = {exp_hi, log_frac};
	assign thr64      = {cfg.threshold_log2, 6'd0};
	assign excess_c   = {{2{lg[23]}}, lg} - {{4{thr64[21]}}, thr64};
	assign excess_pos = !excess_c[25] && (excess_c != '0);

	// reduction: integer part shifts, fraction picks the table entry
	assign rsum    = prod_q[37:0] + 38'd32768;
	assign r       = rsum[37:16];
	assign exp_idx = r[15 -: LOG_TABLE_BITS];
	assign comp_c  = r[21] ? 17'd0 : (recip >> r[20:16]);

	assign gsum = prod_q[32:0] + 33'd32768;
	assign g_c  = gsum[32] ? 16'hFFFF : gsum[31:16];

	assign sat_c    = sat_q12(prod_q[32:0]);
	assign out_free = !res_valid_q || !result_stall;
	assign res_load = (state_q == ST_CH1_SAT) && out_free;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_ENV_MUL: begin
				mul_a = MulW'(rising_q ? cfg.attack_coeff : cfg.release_coeff);
				mul_b = MulW'(diff_q);
			end
			ST_RED_MUL: begin
				mul_a = MulW'(cfg.slope);
				mul_b = MulW'(excess_q);
			end
			ST_MK_MUL: begin
				mul_a = MulW'(comp_q);
				mul_b = MulW'(cfg.makeup_gain);
			end
			ST_CH0_MUL: begin
				mul_a = {{(MulW-16){s0_q[15]}}, s0_q};
				mul_b = MulW'(g_q);
			end
			ST_CH1_MUL, ST_CH1_SAT: begin
				mul_a = {{(MulW-16){s1_q[15]}}, s1_q};
				mul_b = MulW'(g_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			s0_q        <= '0;
			s1_q        <= '0;
			start_q     <= 1'b0;
			two_ch_q    <= 1'b0;
			rising_q    <= 1'b0;
			env_q       <= '0;
			peak_q      <= '0;
			diff_q      <= '0;
			excess_q    <= '0;
			comp_q      <= '0;
			g_q         <= '0;
			o0_q        <= '0;
			clip0_q     <= 1'b0;
			res_valid_q <= 1'b0;
			out_ch0_q   <= '0;
			out_ch1_q   <= '0;
			gain_q      <= '0;
			clip_q      <= 1'b0;
		end else begin
			if (res_load) res_valid_q <= 1'b1;
			else if (res_valid_q && !result_stall) res_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (frame_valid) begin
						s0_q     <= sample_ch0;
						s1_q     <= sample_ch1;
						start_q  <= block_start;
						two_ch_q <= two_ch_c;
						state_q  <= ST_PEAK;
					end
				end
				ST_PEAK: begin
					peak_q   <= peak_c;
					diff_q   <= diff_c;
					rising_q <= rising_c;
					state_q  <= ST_ENV_MUL;
				end
				ST_ENV_MUL: state_q <= ST_ENV_UPD;
				ST_ENV_UPD: begin
					env_q <= env_new;
					if (env_new == '0) begin
						comp_q  <= UnityGain;
						state_q <= ST_MK_MUL;
					end else begin
						state_q <= ST_NORM;
					end
				end
				ST_NORM: begin
					if (norm.last) state_q <= ST_LOG;
				end
				ST_LOG: begin
					if (excess_pos) begin
						excess_q <= excess_c[21:0];
						state_q  <= ST_RED_MUL;
					end else begin
						comp_q  <= UnityGain;
						state_q <= ST_MK_MUL;
					end
				end
				ST_RED_MUL: state_q <= ST_RED;
				ST_RED: begin
					comp_q  <= comp_c;
					state_q <= ST_MK_MUL;
				end
				ST_MK_MUL: state_q <= ST_GAIN;
				ST_GAIN: begin
					g_q     <= g_c;
					state_q <= ST_CH0_MUL;
				end
				ST_CH0_MUL: state_q <= ST_CH1_MUL;
				ST_CH1_MUL: begin
					clip0_q <= sat_c[16];
					o0_q    <= sat_c[15:0];
					state_q <= ST_CH1_SAT;
				end
				ST_CH1_SAT: begin
					// wait here only while the previous result is still held
					if (out_free) begin
						out_ch0_q <= o0_q;
						out_ch1_q <= two_ch_q ? sat_c[15:0] : 16'sd0;
						gain_q    <= g_q;
						clip_q    <= clip0_q | (two_ch_q & sat_c[16]);
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign result_valid = res_valid_q;
	assign out_ch0      = out_ch0_q;
	assign out_ch1      = out_ch1_q;
	assign applied_gain = gain_q;
	assign clipped      = clip_q;

`ifndef SYNTHESIS
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid && !frame_stall |=> state_q == ST_PEAK)
		else $error("accepted frame did not start the sequencer");

	a_norm_msb: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LOG |-> norm.value[EnvW-1])
		else $error("normalizer finished without leading one at the top");

	a_env_bound: assert property (@(posedge clk) disable iff (!arst_n)
		env_q <= EnvMax)
		else $error("envelope above full scale");

	a_comp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MK_MUL |-> comp_q <= UnityGain)
		else $error("compressor gain above unity");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q) == ST_CH1_SAT)
		else $error("result raised outside the final step");
`endif

endmodule

### design/drc_cfg.sv
// Configuration register file for the range compressor.
module drc_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	input  logic [drc_pkg::CfgIndexW-1:0]    cfg_index,
	input  logic [drc_pkg::CfgDataW-1:0]     cfg_data,
	output drc_pkg::drc_cfg_t                cfg
);
	import drc_pkg::*;

	drc_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.channel_count  <= RstChannelCount;
			cfg_q.threshold_log2 <= RstThreshold;
			cfg_q.slope          <= RstSlope;
			cfg_q.attack_coeff   <= RstAttack;
			cfg_q.release_coeff  <= RstRelease;
			cfg_q.makeup_gain    <= RstMakeup;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_CHANNEL_COUNT: cfg_q.channel_count  <= cfg_data[1:0];
				REG_THRESHOLD:     cfg_q.threshold_log2 <= cfg_data[15:0];
				REG_SLOPE:         cfg_q.slope          <= cfg_data[15:0];
				REG_ATTACK:        cfg_q.attack_coeff   <= cfg_data[23:0];
				REG_RELEASE:       cfg_q.release_coeff  <= cfg_data[23:0];
				REG_MAKEUP:        cfg_q.makeup_gain    <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### design/drc_mul.sv
// Shared signed multiplier with registered product.
module drc_mul (
	input  logic                                  clk,
	input  logic signed [drc_pkg::MulW-1:0]       a,
	input  logic signed [drc_pkg::MulW-1:0]       b,
	output logic signed [2*drc_pkg::MulW-1:0]     prod_q
);
	import drc_pkg::*;

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

endmodule

### design/drc_norm.sv
// Leading-one normalizer: binary shift search, one step per cycle.
module drc_norm (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         load,
	input  logic [drc_pkg::EnvW-1:0]     value,
	output drc_pkg::drc_norm_t           status
);
	import drc_pkg::*;

	localparam int CntW = $clog2(NormSteps + 1);

	logic [CntW-1:0] cnt_q;
	logic [EnvW-1:0] value_q;
	logic [4:0]      shamt_q;
	logic [4:0]      amt;
	logic            zero_top;
	logic [4:0]      shift;
	logic            running;

	// step k tests the top 16 >> k bits and shifts them out when they are all zero
	always_comb begin
		case (cnt_q)
			3'd0: begin
				amt = 5'd16;
				zero_top = (value_q[EnvW-1 -: 16] == '0);
			end
			3'd1: begin
				amt = 5'd8;
				zero_top = (value_q[EnvW-1 -: 8] == '0);
			end
			3'd2: begin
				amt = 5'd4;
				zero_top = (value_q[EnvW-1 -: 4] == '0);
			end
			3'd3: begin
				amt = 5'd2;
				zero_top = (value_q[EnvW-1 -: 2] == '0);
			end
			3'd4: begin
				amt = 5'd1;
				zero_top = ~value_q[EnvW-1];
			end
			default: begin
				amt = 5'd0;
				zero_top = 1'b0;
			end
		endcase
	end

	assign shift   = zero_top ? amt : 5'd0;
	assign running = (cnt_q != CntW'(NormSteps));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= CntW'(NormSteps);
		end else if (load) begin
			cnt_q <= '0;
		end else if (running) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			value_q <= value;
			shamt_q <= '0;
		end else if (running) begin
			value_q <= value_q << shift;
			shamt_q <= shamt_q + shift;
		end
	end

	assign status.last  = (cnt_q == CntW'(NormSteps - 1));
	assign status.shamt = shamt_q;
	assign status.value = value_q;

endmodule

### design/drc_tables.sv
// Constant log2-fraction and exp2-reciprocal tables.
module drc_tables #(
	parameter int LOG_TABLE_BITS = drc_pkg::LogTableBitsDef
) (
	input  logic [LOG_TABLE_BITS-1:0] log_idx,
	input  logic [LOG_TABLE_BITS-1:0] exp_idx,
	output logic [15:0]               log_frac,
	output logic [16:0]               recip
);
	import drc_pkg::*;

	localparam int Entries = 1 << LOG_TABLE_BITS;

	logic [15:0] log_tab   [Entries];
	logic [16:0] recip_tab [Entries];

	for (genvar i = 0; i < Entries; i++) begin : g_entry
		localparam logic [15:0] LogVal   = log_entry(64'(i), LOG_TABLE_BITS);
		localparam logic [16:0] RecipVal = recip_entry(64'(i), LOG_TABLE_BITS);
		assign log_tab[i]   = LogVal;
		assign recip_tab[i] = RecipVal;
	end

	assign log_frac = log_tab[log_idx];
	assign recip    = recip_tab[exp_idx];

endmodule

### test/tb_dynamic_range_compressor.sv
`timescale 1ns / 1ps
// Self-checking testbench for the dynamic range compressor: frame stimulus and scoreboard.
module tb_dynamic_range_compressor;
	import drc_pkg::*;

	localparam int TblBits       = LogTableBitsDef;
	localparam int TblSize       = 1 << TblBits;
	localparam int WatchdogLimit = 4000;
	localparam int SettleCycles  = 40;
	localparam int ItemsTarget   = 850;
	localparam int FinalItems    = 150;
	localparam logic [CfgIndexW-1:0] RegSpare6 = 3'd6;
	localparam logic [CfgIndexW-1:0] RegSpare7 = 3'd7;

	typedef struct packed {
		logic signed [15:0] ch0;
		logic signed [15:0] ch1;
		logic [15:0]        gain;
		logic               clip;
	} frame_out_t;

	class gain_scoreboard;
		drc_cfg_t          cfg;
		logic [EnvW-1:0]   env;
		logic [15:0]       log_frac [TblSize];
		longint unsigned   pow_frac [TblSize];
		frame_out_t        expected_q [$];
		int n_frames, n_checked, n_mismatch, n_clipped, n_unity, n_muted;

		function new();
			longint unsigned x, frac, p, rt;
			int i, k;
			// log2 fractions by repeated squaring, 2^(i/2^B) from a chain of square roots
			for (i = 0; i < TblSize; i++) begin
				x = longint'(TblSize + i) << (30 - TblBits);
				frac = 0;
				for (k = 0; k < 16; k++) begin
					x = (x * x) >> 30;
					frac = frac << 1;
					if (x >= (64'd1 << 31)) begin
						frac = frac | 64'd1;
						x = x >> 1;
					end
				end
				log_frac[i] = frac[15:0];
				p = 64'd1 << 30;
				rt = 64'd2 << 30;
				for (k = 1; k <= TblBits; k++) begin
					rt = int_sqrt(rt << 30);
					if (((i >> (TblBits - k)) & 1) != 0) p = (p * rt) >> 30;
				end
				pow_frac[i] = p;
			end
			cfg = {RstChannelCount, RstThreshold, RstSlope, RstAttack, RstRelease, RstMakeup};
			env = '0;
		endfunction

		function longint unsigned int_sqrt(longint unsigned v);
			longint unsigned root, b;
			root = 0;
			b = 64'd1 << 62;
			while (b > v) b = b >> 2;
			while (b != 0) begin
				if (v >= root + b) begin
					v = v - (root + b);
					root = (root >> 1) + b;
				end else begin
					root = root >> 1;
				end
				b = b >> 2;
			end
			return root;
		endfunction

		function longint unsigned magnitude(logic signed [15:0] s);
			return (s < 0) ? -longint'(s) : longint'(s);
		endfunction

		function logic signed [15:0] scale(logic signed [15:0] s, logic [15:0] g, inout bit clip);
			longint q;
			q = (longint'(s) * longint'({1'b0, g}) + 2048) >>> 12;
			if (q > 32767) begin
				q = 32767;
				clip = 1'b1;
			end
			if (q < -32768) begin
				q = -32768;
				clip = 1'b1;
			end
			return q[15:0];
		endfunction

		function void apply_register(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] data);
			case (idx)
				REG_CHANNEL_COUNT: cfg.channel_count = data[1:0];
				REG_THRESHOLD:     cfg.threshold_log2 = data[15:0];
				REG_SLOPE:         cfg.slope = data[15:0];
				REG_ATTACK:        cfg.attack_coeff = data[23:0];
				REG_RELEASE:       cfg.release_coeff = data[23:0];
				REG_MAKEUP:        cfg.makeup_gain = data[15:0];
				default:           ;
			endcase
		endfunction

		// Advance the envelope and queue the expected output for one accepted frame.
		function void note_frame(logic signed [15:0] s0, logic signed [15:0] s1, logic start);
			frame_out_t      want;
			int              nch, m;
			longint unsigned peak, e, idx, comp, red, pw, g;
			longint          lg, excess;
			bit              clip;
			nch = (cfg.channel_count == 2'd0) ? 1 :
				((cfg.channel_count > 2'd2) ? 2 : int'(cfg.channel_count));
			if (nch > MaxChannels) nch = MaxChannels;
			if (start) env = '0;
			peak = magnitude(s0);
			if (nch > 1 && magnitude(s1) > peak) peak = magnitude(s1);
			peak = peak << 8;
			e = env;
			if (peak > e) e = peak - ((cfg.attack_coeff * (peak - e) + (64'd1 << 23)) >> 24);
			else e = peak + ((cfg.release_coeff * (e - peak) + (64'd1 << 23)) >> 24);
			e = e & ((64'd1 << EnvW) - 1);
			env = e[EnvW-1:0];
			comp = 64'd65536;
			if (e != 0) begin
				m = 0;
				while (m < 24 && (e >> (m + 1)) != 0) m++;
				idx = ((m >= TblBits) ? (e >> (m - TblBits)) : (e << (TblBits - m))) &
					(TblSize - 1);
				lg = longint'(m - 23) * 65536 + longint'(log_frac[idx]);
				excess = lg - longint'($signed(cfg.threshold_log2)) * 64;
				if (excess > 0) begin
					red = (cfg.slope * $unsigned(excess) + 32768) >> 16;
					pw = pow_frac[(red & 64'hFFFF) >> (16 - TblBits)];
					comp = ((64'd1 << 46) + pw / 2) / pw;
					comp = ((red >> 16) >= 32) ? 64'd0 : (comp >> (red >> 16));
				end
			end
			g = (comp * cfg.makeup_gain + 32768) >> 16;
			if (g > 65535) g = 65535;
			clip = 1'b0;
			want.ch0 = scale(s0, g[15:0], clip);
			want.ch1 = '0;
			if (nch > 1) want.ch1 = scale(s1, g[15:0], clip);
			want.gain = g[15:0];
			want.clip = clip;
			expected_q.push_back(want);
			n_frames++;
			if (comp == 64'd65536) n_unity++;
			if (comp == 0) n_muted++;
			if (clip) n_clipped++;
		endfunction

		function void check_result(frame_out_t got);
			frame_out_t want;
			if (expected_q.size() == 0) begin
				n_mismatch++;
				if (n_mismatch <= 10)
					$display("Mismatch: result with no frame pending, got %0d %0d gain %0d clip %0b",
						got.ch0, got.ch1, got.gain, got.clip);
				return;
			end
			want = expected_q.pop_front();
			n_checked++;
			if (got !== want) begin
				n_mismatch++;
				if (n_mismatch <= 10) begin
					$display("Mismatch on result %0d: expected ch0 %0d ch1 %0d gain %0d clip %0b",
						n_checked, want.ch0, want.ch1, want.gain, want.clip);
					$display("                       got      ch0 %0d ch1 %0d gain %0d clip %0b",
						got.ch0, got.ch1, got.gain, got.clip);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic frame_valid;
	logic frame_stall;
	logic signed [15:0] sample_ch0;
	logic signed [15:0] sample_ch1;
	logic block_start;
	logic result_valid;
	logic result_stall;
	logic signed [15:0] out_ch0;
	logic signed [15:0] out_ch1;
	logic [15:0] applied_gain;
	logic clipped;
	logic cfg_valid;
	logic cfg_ready;
	logic [CfgIndexW-1:0] cfg_index;
	logic [CfgDataW-1:0] cfg_data;

	gain_scoreboard sb;
	bit idling;
	int sent;
	int settings_used;
	int stuck_cycles;

	dynamic_range_compressor dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.frame_valid  (frame_valid),
		.frame_stall  (frame_stall),
		.sample_ch0   (sample_ch0),
		.sample_ch1   (sample_ch1),
		.block_start  (block_start),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.out_ch0      (out_ch0),
		.out_ch1      (out_ch1),
		.applied_gain (applied_gain),
		.clipped      (clipped),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #2 clk = ~clk;

	// Monitor and watchdog: everything sampled at the rising edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall)
				sb.check_result({out_ch0, out_ch1, applied_gain, clipped});
			if (frame_valid && !frame_stall) sb.note_frame(sample_ch0, sample_ch1, block_start);
			if (cfg_valid && cfg_ready) sb.apply_register(cfg_index, cfg_data);
		end
		if ((frame_valid && !frame_stall) || (result_valid && !result_stall) ||
				(cfg_valid && cfg_ready))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles >= WatchdogLimit) begin
			$display("Timeout: no request accepted for %0d cycles", WatchdogLimit);
			$display("Some tests failed");
			$finish;
		end
	end

	// Receiver back-pressure in random bursts.
	initial begin
		forever begin
			@(negedge clk);
			if (idling && $urandom_range(0, 5) == 0) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 17)) @(negedge clk);
				result_stall <= 1'b0;
			end
		end
	end

	task automatic send_frame(input logic signed [15:0] s0, input logic signed [15:0] s1,
			input logic start);
		@(negedge clk);
		if (idling && $urandom_range(0, 3) == 0) begin
			frame_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		frame_valid <= 1'b1;
		sample_ch0 <= s0;
		sample_ch1 <= s1;
		block_start <= start;
		do @(posedge clk); while (!(frame_valid && !frame_stall));
		sent++;
	endtask

	task automatic post_register(input logic [CfgIndexW-1:0] idx,
			input logic [CfgDataW-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	// Registers only change with the pipe empty; unused upper data bits carry noise.
	task automatic configure(input logic [1:0] nch, input logic [15:0] thr,
			input logic [15:0] slp, input logic [23:0] atk, input logic [23:0] rel,
			input logic [15:0] mk);
		@(negedge clk);
		frame_valid <= 1'b0;
		drain();
		post_register(REG_CHANNEL_COUNT, {22'($urandom), nch});
		post_register(REG_THRESHOLD, {8'($urandom), thr});
		post_register(REG_SLOPE, {8'($urandom), slp});
		post_register(REG_ATTACK, atk);
		post_register(REG_RELEASE, rel);
		post_register(REG_MAKEUP, {8'($urandom), mk});
		settings_used++;
	endtask

	function automatic logic [23:0] random_coeff();
		case ($urandom_range(0, 5))
			0: return 24'd0;
			1: return 24'hFFFFFF;
			2, 3: return 24'($urandom);
			default: return 24'hFFFFFF - 24'($urandom_range(0, 24'h3FFFF));
		endcase
	endfunction

	function automatic logic signed [15:0] random_sample(input int level);
		int mag;
		case ($urandom_range(0, 9))
			0: return 16'($urandom);
			1: return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
			default: begin
				mag = $urandom_range(0, level);
				return 16'(($urandom_range(0, 1) != 0) ? -mag : mag);
			end
		endcase
	endfunction

	task automatic randomize_settings();
		logic [15:0] thr, mk;
		case ($urandom_range(0, 7))
			0: thr = 16'($urandom);
			1: thr = 16'h8000;
			2: thr = 16'd0;
			default: thr = 16'(-$urandom_range(0, 12288));
		endcase
		case ($urandom_range(0, 7))
			0: mk = 16'd0;
			1: mk = 16'hFFFF;
			2: mk = 16'($urandom);
			default: mk = 16'($urandom_range(2048, 16384));
		endcase
		configure(2'($urandom), thr, ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom),
			random_coeff(), random_coeff(), mk);
	endtask

	// Program material: level steps so the envelope sees both attack and release.
	task automatic run_frames(input int count);
		int i, level;
		level = 32767;
		for (i = 0; i < count; i++) begin
			if ($urandom_range(0, 24) == 0)
				level = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 1023) :
					$urandom_range(1024, 32767);
			send_frame(random_sample(level), random_sample(level),
				(i == 0) || ($urandom_range(0, 19) == 0));
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		frame_valid = 1'b0;
		sample_ch0 = '0;
		sample_ch1 = '0;
		block_start = 1'b0;
		result_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_CHANNEL_COUNT;
		cfg_data = '0;
		idling = 1'b0;
		sent = 0;
		settings_used = 1;
		stuck_cycles = 0;
		sb = new();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// defaults: zero envelope, below knee, full scale, start flag
		send_frame(16'sd0, 16'sd0, 1'b1);
		send_frame(16'sd100, -16'sd100, 1'b0);
		send_frame(16'sh7FFF, 16'sh8000, 1'b0);
		send_frame(16'sh8000, 16'sh7FFF, 1'b0);
		send_frame(16'sd1, -16'sd1, 1'b1);
		send_frame(-16'sd1, 16'sd0, 1'b0);
		send_frame(16'sd16384, 16'sh5555, 1'b0);
		send_frame(16'shAAAA, 16'sd0, 1'b0);

		// single channel, instant envelope, max makeup: clipping on ch0 only
		configure(2'd1, RstThreshold, RstSlope, 24'd0, 24'd0, 16'hFFFF);
		send_frame(16'sh7FFF, 16'sh1234, 1'b1);
		send_frame(16'sh8000, -16'sd5, 1'b0);
		send_frame(16'sd200, 16'sh7FFF, 1'b0);

		// channel count zero; lowest threshold and full slope drive the gain to zero
		configure(2'd0, 16'h8000, 16'hFFFF, 24'd0, 24'hFFFFFF, RstMakeup);
		send_frame(16'sh7FFF, 16'sd0, 1'b1);
		send_frame(16'sh8000, 16'sd7, 1'b0);
		send_frame(16'sd3, 16'sh7FFF, 1'b0);

		// channel count three, positive threshold, zero makeup
		configure(2'd3, 16'h7FFF, 16'd0, 24'h800000, 24'h800000, 16'd0);
		send_frame(16'sh7FFF, 16'sh8000, 1'b1);
		send_frame(16'sh4000, 16'shC000, 1'b0);

		configure(2'd2, 16'd0, 16'hFFFF, 24'h000001, 24'hFFFFFE, 16'h1000);
		send_frame(16'sh7FFF, 16'sh7FFF, 1'b1);
		send_frame(16'sh8000, 16'sh8000, 1'b0);

		// writes to unmapped indexes must leave the settings alone
		@(negedge clk);
		frame_valid <= 1'b0;
		drain();
		post_register(RegSpare6, 24'($urandom));
		post_register(RegSpare7, 24'($urandom));
		send_frame(16'sh7FFF, 16'sd0, 1'b1);

		while (sent < ItemsTarget - FinalItems) begin
			randomize_settings();
			idling = ($urandom_range(0, 3) != 0);
			run_frames($urandom_range(30, 90));
		end
		idling = 1'b0;
		randomize_settings();
		run_frames(FinalItems);
		@(negedge clk);
		frame_valid <= 1'b0;
		drain();

		$display("Sent %0d frames under %0d register settings; %0d results checked, %0d bad.",
			sent, settings_used, sb.n_checked, sb.n_mismatch);
		$display("Frames clipped: %0d, at unity compressor gain: %0d, fully attenuated: %0d.",
			sb.n_clipped, sb.n_unity, sb.n_muted);
		if (sb.n_mismatch == 0 && sb.expected_q.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

### dynamic_range_compressor.f
design/drc_pkg.sv
design/drc_cfg.sv
design/drc_mul.sv
design/drc_norm.sv
design/drc_tables.sv
design/dynamic_range_compressor.sv
test/tb_dynamic_range_compressor.sv
